// File: rtl/sns_pkg.sv
// Shared types and constants for the spoken-number one-wire sender.
package sns_pkg;

    localparam int MAX_PHRASE  = 6;
    localparam int POS_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] NUMBER_LIMIT = 16'd1000;

    // Configuration register indexes
    localparam logic [2:0] REG_START_LOW     = 3'd0;
    localparam logic [2:0] REG_LONG          = 3'd1;
    localparam logic [2:0] REG_SHORT         = 3'd2;
    localparam logic [2:0] REG_DIGIT_BASE    = 3'd3;
    localparam logic [2:0] REG_TENS_WORD     = 3'd4;
    localparam logic [2:0] REG_HUNDREDS_WORD = 3'd5;
    localparam logic [2:0] REG_UNITS_WORD    = 3'd6;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_START_LOW     = 8'h05;
    localparam logic [7:0] RST_LONG          = 8'h03;
    localparam logic [7:0] RST_SHORT         = 8'h01;
    localparam logic [7:0] RST_DIGIT_BASE    = 8'h0c;
    localparam logic [7:0] RST_TENS_WORD     = 8'h16;
    localparam logic [7:0] RST_HUNDREDS_WORD = 8'h17;
    localparam logic [7:0] RST_UNITS_WORD    = 8'h18;

    typedef struct packed {
        logic [7:0] start_low_ticks;
        logic [7:0] long_ticks;
        logic [7:0] short_ticks;
        logic [7:0] digit_base_code;
        logic [7:0] tens_word_code;
        logic [7:0] hundreds_word_code;
        logic [7:0] units_word_code;
    } cfg_t;

    // Classified transaction handed from the front to the back
    typedef struct packed {
        logic       is_play;
        logic       in_range;
        logic       busy_level;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } cmd_t;

    typedef struct packed {
        logic line_level;
        logic idle;
        logic request_dropped;
    } result_t;

endpackage

// File: rtl/sns_if.sv
// Handshake channels for requests and results.
interface sns_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] number;
    logic        busy_level;

    modport source (output valid, output req_type, output number, output busy_level,
                    input ready);
    modport sink   (input valid, input req_type, input number, input busy_level,
                    output ready);
endinterface

interface sns_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic idle;
    logic request_dropped;

    modport source (output valid, output line_level, output idle, output request_dropped,
                    input ready);
    modport sink   (input valid, input line_level, input idle, input request_dropped,
                    output ready);
endinterface

// File: rtl/sns_front.sv
// Front end: classifies a request and splits the number into decimal digits.
module sns_front (
    input  logic          req_type,
    input  logic [15:0]   number,
    input  logic          busy_level,
    output sns_pkg::cmd_t cmd
);
    import sns_pkg::*;

    logic [9:0]  n10;
    logic [15:0] h_prod;
    logic [3:0]  h_est;
    logic [9:0]  rem_est;
    logic        h_fix;
    logic [3:0]  hundreds;
    logic [6:0]  rem;
    logic [14:0] t_prod;
    logic [3:0]  tens;
    logic [6:0]  t_times10;

    assign n10 = number[9:0];

    // n / 100 by reciprocal 41 / 4096, then one correction step
    assign h_prod  = 16'(n10) * 16'd41;
    assign h_est   = h_prod[15:12];
    assign rem_est = n10 - 10'(h_est) * 10'd100;
    assign h_fix   = (rem_est >= 10'd100);
    assign hundreds = h_fix ? h_est + 4'd1 : h_est;
    assign rem      = h_fix ? 7'(rem_est - 10'd100) : rem_est[6:0];

    // rem / 10 by reciprocal 205 / 2048, exact below 1029
    assign t_prod    = 15'(rem) * 15'd205;
    assign tens      = t_prod[14:11];
    assign t_times10 = 7'(tens) * 7'd10;

    always_comb
    begin
        cmd.is_play    = req_type;
        cmd.in_range   = (number < NUMBER_LIMIT);
        cmd.busy_level = busy_level;
        cmd.hundreds   = hundreds;
        cmd.tens       = tens;
        cmd.ones       = 4'(rem - t_times10);
    end

endmodule

// File: rtl/sns_queue.sv
// Two-entry queue between the front end and the line sequencer.
module sns_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sns_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sns_pkg::cmd_t head_data
);
    import sns_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/sns_back.sv
// Line sequencer: builds the phrase and drives the pulse-width frames tick by tick.
module sns_back (
    input  logic            clk,
    input  logic            rst_n,
    input  sns_pkg::cfg_t   cfg,
    input  logic            cmd_valid,
    input  sns_pkg::cmd_t   cmd,
    output logic            cmd_pop,
    output logic            res_valid,
    input  logic            res_ready,
    output sns_pkg::result_t res
);
    import sns_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_HIGH  = 3'd2;
    localparam logic [2:0] PH_LOW   = 3'd3;
    localparam logic [2:0] PH_WAIT  = 3'd4;

    logic [2:0]       phase_reg,    phase_next;
    logic [7:0]       tick_reg,     tick_next;
    logic [7:0]       shift_reg,    shift_next;
    logic [2:0]       bit_reg,      bit_next;
    logic [POS_W-1:0] length_reg,   length_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [7:0]       codes_reg [MAX_PHRASE];
    logic [7:0]       codes_next [MAX_PHRASE];
    logic             codes_we;
    logic             res_valid_reg, res_valid_next;
    result_t          res_reg, res_next;

    logic             cur_level;
    logic [7:0]       dur_raw;
    logic [7:0]       dur;
    logic [7:0]       tick_inc;
    logic [7:0]       code_h;
    logic [7:0]       code_t;
    logic [7:0]       code_o;
    logic [POS_W-1:0] position_inc;

    assign cmd_pop   = cmd_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign cur_level = !(phase_reg == PH_START || phase_reg == PH_LOW);
    assign tick_inc  = tick_reg + 8'd1;
    assign code_h    = cfg.digit_base_code + 8'(cmd.hundreds);
    assign code_t    = cfg.digit_base_code + 8'(cmd.tens);
    assign code_o    = cfg.digit_base_code + 8'(cmd.ones);
    assign position_inc = position_reg + 1'b1;

    always_comb
    begin
        unique case (phase_reg)
            PH_START: dur_raw = cfg.start_low_ticks;
            PH_HIGH:  dur_raw = shift_reg[0] ? cfg.long_ticks : cfg.short_ticks;
            default:  dur_raw = shift_reg[0] ? cfg.short_ticks : cfg.long_ticks;
        endcase
        // a zero duration counts as one tick
        dur = (dur_raw == 8'd0) ? 8'd1 : dur_raw;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        shift_next    = shift_reg;
        bit_next      = bit_reg;
        length_next   = length_reg;
        position_next = position_reg;
        codes_next    = codes_reg;
        codes_we      = 1'b0;
        res_next      = res_reg;
        res_next.line_level      = cur_level;
        res_next.request_dropped = 1'b0;

        if (cmd.is_play)
        begin
            if (phase_reg != PH_IDLE || !cmd.in_range)
            begin
                res_next.request_dropped = 1'b1;
            end
            else
            begin
                codes_we = 1'b1;
                if (cmd.hundreds != 4'd0)
                begin
                    codes_next[0] = code_h;
                    codes_next[1] = cfg.hundreds_word_code;
                    codes_next[2] = code_t;
                    codes_next[3] = cfg.tens_word_code;
                    codes_next[4] = code_o;
                    codes_next[5] = cfg.units_word_code;
                    length_next   = POS_W'(6);
                end
                else if (cmd.tens != 4'd0)
                begin
                    codes_next[0] = code_t;
                    codes_next[1] = cfg.tens_word_code;
                    codes_next[2] = code_o;
                    codes_next[3] = cfg.units_word_code;
                    length_next   = POS_W'(4);
                end
                else
                begin
                    codes_next[0] = code_o;
                    codes_next[1] = cfg.units_word_code;
                    length_next   = POS_W'(2);
                end
                position_next = '0;
                shift_next    = codes_next[0];
                bit_next      = '0;
                tick_next     = '0;
                phase_next    = PH_START;
                res_next.line_level = 1'b0;
            end
        end
        else if (phase_reg == PH_WAIT)
        begin
            // advance once the chip reports it has finished the last code
            if (cmd.busy_level)
            begin
                position_next = position_inc;
                if (position_inc < length_reg)
                begin
                    shift_next = codes_reg[position_inc];
                    bit_next   = '0;
                    tick_next  = '0;
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_next = tick_inc;
            if (tick_inc >= dur)
            begin
                tick_next = '0;
                unique case (phase_reg)
                    PH_START: phase_next = PH_HIGH;
                    PH_HIGH:  phase_next = PH_LOW;
                    default:
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        if (bit_reg == 3'd7)
                        begin
                            bit_next   = '0;
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 1'b1;
                            phase_next = PH_HIGH;
                        end
                    end
                endcase
            end
        end

        res_next.idle = (phase_next == PH_IDLE);
        res_valid_next = cmd_pop || (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            shift_reg     <= '0;
            bit_reg       <= '0;
            length_reg    <= '0;
            position_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd_pop)
            begin
                phase_reg    <= phase_next;
                tick_reg     <= tick_next;
                shift_reg    <= shift_next;
                bit_reg      <= bit_next;
                length_reg   <= length_next;
                position_reg <= position_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_reg <= res_next;
            if (codes_we)
            begin
                codes_reg <= codes_next;
            end
        end
    end

endmodule

// File: rtl/spoken_number_one_wire_sender.sv
// Top level of the spoken-number one-wire sender.
//
//  channel   dir  handshake      payload
//  request   in   valid/ready    req_type, number[15:0], busy_level
//  result    out  valid/ready    line_level, idle, request_dropped
//  cfg       in   cfg_wr_en      cfg_index[2:0], cfg_data[7:0]
//
// One result per transaction; a transaction enters every cycle while the queue has room,
// and its result is registered and appears in the cycle after it leaves the two-entry
// queue into the sequencer. The sequencer state update (tick counter, shift register,
// phase) is the loop that sets the rate of one transaction per clock unless results stall.
// Reset clears the phase, counters and queue; configuration returns to defaults.
// A stalled result holds; the queue keeps taking requests until it is full.
module spoken_number_one_wire_sender (
    input  logic       clk,
    input  logic       rst_n,
    sns_req_if.sink    request,
    sns_res_if.source  result,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import sns_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    front_cmd;
    cmd_t    head_cmd;
    logic    queue_full;
    logic    head_valid;
    logic    head_pop;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks    <= RST_START_LOW;
            cfg_reg.long_ticks         <= RST_LONG;
            cfg_reg.short_ticks        <= RST_SHORT;
            cfg_reg.digit_base_code    <= RST_DIGIT_BASE;
            cfg_reg.tens_word_code     <= RST_TENS_WORD;
            cfg_reg.hundreds_word_code <= RST_HUNDREDS_WORD;
            cfg_reg.units_word_code    <= RST_UNITS_WORD;
        end
        else if (cfg_wr_en)
        begin
            // drop writes to unused indexes
            unique case (cfg_index)
                REG_START_LOW:     cfg_reg.start_low_ticks    <= cfg_data;
                REG_LONG:          cfg_reg.long_ticks         <= cfg_data;
                REG_SHORT:         cfg_reg.short_ticks        <= cfg_data;
                REG_DIGIT_BASE:    cfg_reg.digit_base_code    <= cfg_data;
                REG_TENS_WORD:     cfg_reg.tens_word_code     <= cfg_data;
                REG_HUNDREDS_WORD: cfg_reg.hundreds_word_code <= cfg_data;
                REG_UNITS_WORD:    cfg_reg.units_word_code    <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    sns_front u_front (
        .req_type   (request.req_type),
        .number     (request.number),
        .busy_level (request.busy_level),
        .cmd        (front_cmd)
    );

    assign request.ready = !queue_full;

    sns_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (request.valid && !queue_full),
        .push_data  (front_cmd),
        .full       (queue_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_data  (head_cmd)
    );

    sns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (head_pop),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (res)
    );

    assign result.line_level      = res.line_level;
    assign result.idle            = res.idle;
    assign result.request_dropped = res.request_dropped;

endmodule

// File: dv/tb_spoken_number_one_wire_sender.sv
// Self-checking testbench for the spoken-number one-wire sender.
`timescale 1ns / 1ps

module tb_spoken_number_one_wire_sender;
    import sns_pkg::*;

    localparam logic       REQ_TICK = 1'b0;
    localparam logic       REQ_PLAY = 1'b1;
    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int         SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START_LOW,
        SEQ_BIT_HIGH,
        SEQ_BIT_LOW,
        SEQ_AWAIT_BUSY
    } seq_phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic       cfg_wr_en;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    sns_req_if request_ch ();
    sns_res_if result_ch ();

    spoken_number_one_wire_sender uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Line model state and register copy
    logic [7:0] mdl_reg [0:6];
    seq_phase_t mdl_phase;
    logic [7:0] mdl_ticks;
    logic [7:0] mdl_shift;
    logic [2:0] mdl_bit;
    logic [7:0] mdl_phrase [0:MAX_PHRASE-1];
    logic [2:0] mdl_len;
    logic [2:0] mdl_pos;

    result_t     pending_line_q [$];
    int unsigned src_gap_pct;
    int unsigned snk_stall_pct;
    int unsigned sent_items;
    int unsigned mismatch_cnt;

    function automatic void reset_line_model();
        mdl_reg[REG_START_LOW]     = RST_START_LOW;
        mdl_reg[REG_LONG]          = RST_LONG;
        mdl_reg[REG_SHORT]         = RST_SHORT;
        mdl_reg[REG_DIGIT_BASE]    = RST_DIGIT_BASE;
        mdl_reg[REG_TENS_WORD]     = RST_TENS_WORD;
        mdl_reg[REG_HUNDREDS_WORD] = RST_HUNDREDS_WORD;
        mdl_reg[REG_UNITS_WORD]    = RST_UNITS_WORD;
        mdl_phase = SEQ_IDLE;
        mdl_ticks = '0;
        mdl_shift = '0;
        mdl_bit   = '0;
        mdl_len   = '0;
        mdl_pos   = '0;
        for (int i = 0; i < MAX_PHRASE; i++)
            mdl_phrase[i] = '0;
    endfunction

    function automatic void push_code(input logic [7:0] code);
        if (mdl_len < MAX_PHRASE)
        begin
            mdl_phrase[mdl_len] = code;
            mdl_len = mdl_len + 3'd1;
        end
    endfunction

    function automatic void load_code();
        mdl_shift = mdl_phrase[mdl_pos];
        mdl_bit   = '0;
        mdl_ticks = '0;
        mdl_phase = SEQ_START_LOW;
    endfunction

    // Length of the current half of a frame; zero acts as one tick
    function automatic logic [7:0] half_ticks();
        logic [7:0] d;
        if (mdl_phase == SEQ_START_LOW)
            d = mdl_reg[REG_START_LOW];
        else if ((mdl_phase == SEQ_BIT_HIGH) == mdl_shift[0])
            d = mdl_reg[REG_LONG];
        else
            d = mdl_reg[REG_SHORT];
        return (d == 8'd0) ? 8'd1 : d;
    endfunction

    function automatic result_t line_step(input logic rt, input logic [15:0] num,
                                          input logic busy);
        int unsigned h;
        int unsigned t;
        int unsigned o;
        logic [7:0]  dur;
        result_t     r;
        r.request_dropped = 1'b0;
        if (rt == REQ_PLAY)
        begin
            if (mdl_phase != SEQ_IDLE || num >= NUMBER_LIMIT)
                r.request_dropped = 1'b1;
            else
            begin
                h = num / 100;
                t = (num % 100) / 10;
                o = num % 10;
                mdl_len = '0;
                mdl_pos = '0;
                if (h != 0)
                begin
                    push_code(mdl_reg[REG_DIGIT_BASE] + 8'(h));
                    push_code(mdl_reg[REG_HUNDREDS_WORD]);
                end
                if (h != 0 || t != 0)
                begin
                    push_code(mdl_reg[REG_DIGIT_BASE] + 8'(t));
                    push_code(mdl_reg[REG_TENS_WORD]);
                end
                push_code(mdl_reg[REG_DIGIT_BASE] + 8'(o));
                push_code(mdl_reg[REG_UNITS_WORD]);
                load_code();
            end
            r.line_level = !(mdl_phase == SEQ_START_LOW || mdl_phase == SEQ_BIT_LOW);
        end
        else
        begin
            r.line_level = !(mdl_phase == SEQ_START_LOW || mdl_phase == SEQ_BIT_LOW);
            if (mdl_phase == SEQ_AWAIT_BUSY)
            begin
                if (busy)
                begin
                    mdl_pos = mdl_pos + 3'd1;
                    if (mdl_pos < mdl_len)
                        load_code();
                    else
                        mdl_phase = SEQ_IDLE;
                end
            end
            else if (mdl_phase != SEQ_IDLE)
            begin
                dur = half_ticks();
                mdl_ticks = mdl_ticks + 8'd1;
                if (mdl_ticks >= dur)
                begin
                    mdl_ticks = '0;
                    case (mdl_phase)
                        SEQ_START_LOW: mdl_phase = SEQ_BIT_HIGH;
                        SEQ_BIT_HIGH:  mdl_phase = SEQ_BIT_LOW;
                        default:
                        begin
                            mdl_shift = mdl_shift >> 1;
                            if (mdl_bit == 3'd7)
                            begin
                                mdl_bit   = '0;
                                mdl_phase = SEQ_AWAIT_BUSY;
                            end
                            else
                            begin
                                mdl_bit   = mdl_bit + 3'd1;
                                mdl_phase = SEQ_BIT_HIGH;
                            end
                        end
                    endcase
                end
            end
        end
        r.idle = (mdl_phase == SEQ_IDLE);
        return r;
    endfunction

    // Receiver: random stalls
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input result_t want,
                                   input result_t got);
        if (mismatch_cnt < 10)
            $display("MISMATCH %s: expected line/idle/dropped=%0b/%0b/%0b, got %0b/%0b/%0b",
                     what, want.line_level, want.idle, want.request_dropped,
                     got.line_level, got.idle, got.request_dropped);
        mismatch_cnt++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.line_level      = result_ch.line_level;
            got.idle            = result_ch.idle;
            got.request_dropped = result_ch.request_dropped;
            if (pending_line_q.size() == 0)
                report_mismatch("result with nothing pending", '0, got);
            else
            begin
                want = pending_line_q.pop_front();
                if (got.line_level !== want.line_level || got.idle !== want.idle ||
                    got.request_dropped !== want.request_dropped)
                    report_mismatch("field mismatch", want, got);
            end
        end
    end

    // Drive one transaction, wait for it to be taken, then predict its result
    task automatic send_item(input logic rt, input logic [15:0] num, input logic busy);
        while ($urandom_range(99) < src_gap_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid      <= 1'b1;
        request_ch.req_type   <= rt;
        request_ch.number     <= num;
        request_ch.busy_level <= busy;
        do
            @(posedge clk);
        while (!request_ch.ready);
        pending_line_q.push_back(line_step(rt, num, busy));
        sent_items++;
    endtask

    task automatic hold_until_drained();
        request_ch.valid <= 1'b0;
        while (pending_line_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Tick until the phrase is over; busy reads high 35 percent of the time in the wait, at random elsewhere
    task automatic finish_phrase();
        logic busy;
        while (mdl_phase != SEQ_IDLE)
        begin
            if ($urandom_range(99) < 3)
                send_item(REQ_PLAY, 16'($urandom), 1'($urandom_range(1)));
            else if ($urandom_range(299) == 0)
                hold_until_drained();
            else
            begin
                if (mdl_phase == SEQ_AWAIT_BUSY)
                    busy = ($urandom_range(99) < 35);
                else
                    busy = 1'($urandom_range(1));
                send_item(REQ_TICK, 16'($urandom), busy);
            end
        end
    endtask

    task automatic speak_number(input logic [15:0] num);
        send_item(REQ_PLAY, num, 1'($urandom_range(1)));
        finish_phrase();
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx <= REG_UNITS_WORD)
            mdl_reg[idx] = val;
    endtask

    task automatic load_config(input logic [7:0] start_low, input logic [7:0] long_t,
                               input logic [7:0] short_t, input logic [7:0] base,
                               input logic [7:0] tens_w, input logic [7:0] hund_w,
                               input logic [7:0] units_w);
        finish_phrase();
        hold_until_drained();
        write_reg(REG_START_LOW, start_low);
        write_reg(REG_LONG, long_t);
        write_reg(REG_SHORT, short_t);
        write_reg(REG_DIGIT_BASE, base);
        write_reg(REG_TENS_WORD, tens_w);
        write_reg(REG_HUNDREDS_WORD, hund_w);
        write_reg(REG_UNITS_WORD, units_w);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] rand_duration();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(12));
        return 8'($urandom_range(3));
    endfunction

    task automatic test_idle_and_drops();
        send_item(REQ_TICK, 16'h0000, 1'b0);
        send_item(REQ_TICK, 16'hFFFF, 1'b1);
        send_item(REQ_PLAY, NUMBER_LIMIT, 1'b0);
        send_item(REQ_PLAY, 16'hFFFF, 1'b1);
        send_item(REQ_PLAY, 16'h8000, 1'b0);
        send_item(REQ_PLAY, 16'h7FFF, 1'b0);
        send_item(REQ_TICK, 16'h5555, 1'b1);
        speak_number(16'd7);
    endtask

    task automatic test_phrase_shapes();
        load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'hFF, 8'h5A);
        speak_number(16'd0);
        speak_number(16'd9);
        speak_number(16'd10);
        speak_number(16'd90);
        speak_number(16'd100);
        speak_number(16'd905);
        speak_number(16'd999);
        // second request lands while the first phrase is active
        send_item(REQ_PLAY, 16'd12, 1'b0);
        send_item(REQ_PLAY, 16'd34, 1'b1);
        send_item(REQ_PLAY, 16'd2000, 1'b0);
        finish_phrase();
        hold_until_drained();
        write_reg(REG_NONE, 8'hFF);
        cfg_wr_en <= 1'b0;
        speak_number(16'd47);
    endtask

    task automatic test_digit_wrap();
        load_config(8'd1, 8'd1, 8'd1, 8'd255, 8'd22, 8'd23, 8'd24);
        speak_number(16'd999);
        speak_number(16'd0);
        load_config(8'd2, 8'd2, 8'd1, 8'd246, 8'd255, 8'd0, 8'd128);
        speak_number(16'd999);
    endtask

    // Full-scale start period with zero-length long half
    task automatic test_long_durations();
        load_config(8'd255, 8'd0, 8'd2, 8'd12, 8'd22, 8'd23, 8'd24);
        speak_number(16'd0);
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                       input int unsigned count);
        int unsigned goal;
        int unsigned pick;
        finish_phrase();
        hold_until_drained();
        src_gap_pct   = src_pct;
        snk_stall_pct = snk_pct;
        load_config(rand_duration(), rand_duration(), rand_duration(),
                    8'($urandom_range(255)), 8'($urandom), 8'($urandom), 8'($urandom));
        goal = sent_items + count;
        while (sent_items < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                speak_number(16'($urandom_range(999)));
            else if (pick < 45)
                speak_number(16'($urandom_range(99)));
            else if (pick < 60)
                speak_number(16'($urandom_range(9)));
            else if (pick < 78)
                send_item(REQ_PLAY, 16'($urandom_range(65535, 1000)), 1'($urandom_range(1)));
            else if (pick < 97)
                send_item(REQ_TICK, 16'($urandom), 1'($urandom_range(1)));
            else
                hold_until_drained();
        end
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        request_ch.valid      <= 1'b0;
        request_ch.req_type   <= REQ_TICK;
        request_ch.number     <= '0;
        request_ch.busy_level <= 1'b0;
        src_gap_pct   = 19;
        snk_stall_pct = 73;
        sent_items    = 0;
        mismatch_cnt  = 0;
        reset_line_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_drops();
        test_phrase_shapes();
        test_digit_wrap();
        test_random_traffic(19, 73, 40);
        test_random_traffic(73, 19, 40);
        test_random_traffic(0, 0, 40);
        test_long_durations();

        finish_phrase();
        hold_until_drained();
        if (pending_line_q.size() != 0)
        begin
            $display("MISMATCH %0d transactions never produced a result",
                     pending_line_q.size());
            mismatch_cnt += pending_line_q.size();
        end
        if (mismatch_cnt == 0)
            $display("spoken_number_one_wire_sender verification clean");
        else
            $display("spoken_number_one_wire_sender verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("spoken_number_one_wire_sender verification failed");
        $finish;
    end

endmodule
